>>> src/mrpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin primality test package
// Widths, the fixed witness table and the modular add used by the core.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int WORD_W             = 64;
  localparam int LIMIT_W            = 4;
  localparam int WIT_W              = 6;
  localparam int SHIFT_W            = 6;
  localparam int MAX_WITNESSES      = 12;
  localparam int WITNESS_TABLE_SIZE = 12;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(12);

  typedef logic [WORD_W-1:0] word_t;

  // The first twelve primes, tried in order.
  function automatic logic [WIT_W-1:0] witness(input logic [LIMIT_W-1:0] idx);
    logic [WIT_W-1:0] w;
    case (idx)
      4'd0:    w = 6'd2;
      4'd1:    w = 6'd3;
      4'd2:    w = 6'd5;
      4'd3:    w = 6'd7;
      4'd4:    w = 6'd11;
      4'd5:    w = 6'd13;
      4'd6:    w = 6'd17;
      4'd7:    w = 6'd19;
      4'd8:    w = 6'd23;
      4'd9:    w = 6'd29;
      4'd10:   w = 6'd31;
      4'd11:   w = 6'd37;
      default: w = 6'd0;
    endcase
    return w;
  endfunction

  // (x + y) mod m for x, y below m, with the carry out of the top bit kept.
  function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
    logic [WORD_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_W-1:0];
  endfunction

endpackage

>>> src/miller_rabin_primality_test_64_core.sv
`timescale 1ns / 1ps
// Special candidates (below 2, 2, 3, even) answer in the cycle after the request.
// Odd candidates run the full test on the bit-serial modular multiplier: one step per
// cycle, up to 126 products per witness. Throughput is one request at a time; busy
// stays high meanwhile. The result shows on done_o for one cycle and cannot be stalled.
// Reset is asynchronous and active low; the witness limit resets to twelve.
// ----------------------------------------------------------------------------
// Miller-Rabin 64-bit primality test core
// Deterministic Miller-Rabin over the first twelve primes, or fewer as set by the
// witness limit, using one shared modular add/double unit under a small sequencer.
// ----------------------------------------------------------------------------
module miller_rabin_primality_test_64_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mrpt_pkg::WORD_W-1:0]   candidate_i,
  output logic                          done_o,
  output logic                          prime_flag_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mrpt_pkg::LIMIT_W-1:0]  cfg_witness_limit_i
);
  import mrpt_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SPLIT  = 3'd1;  // strip factors of two from n - 1
  localparam logic [2:0] S_WIT    = 3'd2;  // pick the next witness
  localparam logic [2:0] S_POW    = 3'd3;  // one square-and-multiply decision
  localparam logic [2:0] S_MUL    = 3'd4;  // bit-serial modular multiply
  localparam logic [2:0] S_PCHK   = 3'd5;  // check a^d against 1 and n - 1
  localparam logic [2:0] S_SQLOOP = 3'd6;  // repeated squaring loop control
  localparam logic [2:0] S_DONE   = 3'd7;

  // What the running product is for, so the multiplier knows where to return.
  localparam logic [1:0] K_ACC  = 2'd0;   // pow accumulator times base
  localparam logic [1:0] K_BASE = 2'd1;   // pow base squared
  localparam logic [1:0] K_SQR  = 2'd2;   // witness value squared

  logic [2:0]         state_q, state_d;
  logic [1:0]         kind_q, kind_d;
  logic               flag_q, flag_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] count_q, count_d;
  logic [LIMIT_W-1:0] widx_q, widx_d;
  logic [SHIFT_W-1:0] r_q, r_d;
  logic [SHIFT_W-1:0] j_q, j_d;
  word_t              n_q, n_d;
  word_t              d_q, d_d;
  word_t              e_q, e_d;
  word_t              acc_q, acc_d;    // pow accumulator, later the witness value x
  word_t              base_q, base_d;  // pow base
  word_t              macc_q, macc_d;  // multiplier accumulator
  word_t              ma_q, ma_d;      // multiplier doubled addend
  word_t              my_q, my_d;      // multiplier remaining bits

  word_t              n_minus_1;
  word_t              wit;
  word_t              sum_acc;
  word_t              sum_dbl;

  assign n_minus_1 = n_q - word_t'(1);
  assign wit       = word_t'(witness(widx_q));

  // The shared unit: one add-and-reduce for the accumulator and one doubling.
  assign sum_acc = add_mod(macc_q, ma_q, n_q);
  assign sum_dbl = add_mod(ma_q, ma_q, n_q);

  assign busy         = (state_q != S_IDLE);
  assign done_o       = (state_q == S_DONE);
  assign prime_flag_o = flag_q;
  // The limit only changes between requests.
  assign cfg_ready_o  = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    flag_d  = flag_q;
    count_d = count_q;
    widx_d  = widx_q;
    r_d     = r_q;
    j_d     = j_q;
    n_d     = n_q;
    d_d     = d_q;
    e_d     = e_q;
    acc_d   = acc_q;
    base_d  = base_q;
    macc_d  = macc_q;
    ma_d    = ma_q;
    my_d    = my_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          n_d = candidate_i;
          d_d = candidate_i - word_t'(1);
          r_d = '0;
          if (candidate_i < word_t'(2)) begin
            flag_d  = 1'b0;
            state_d = S_DONE;
          end else if (candidate_i == word_t'(2) || candidate_i == word_t'(3)) begin
            flag_d  = 1'b1;
            state_d = S_DONE;
          end else if (!candidate_i[0]) begin
            flag_d  = 1'b0;
            state_d = S_DONE;
          end else begin
            state_d = S_SPLIT;
          end
        end
      end

      S_SPLIT: begin
        if (!d_q[0]) begin
          d_d = d_q >> 1;
          r_d = r_q + SHIFT_W'(1);
        end else begin
          widx_d  = '0;
          count_d = (limit_q > LIMIT_W'(MAX_WITNESSES)) ? LIMIT_W'(MAX_WITNESSES) : limit_q;
          state_d = S_WIT;
        end
      end

      S_WIT: begin
        if (widx_q == count_q) begin
          flag_d  = 1'b1;
          state_d = S_DONE;
        end else if (wit >= n_q) begin
          widx_d = widx_q + LIMIT_W'(1);
        end else begin
          acc_d   = word_t'(1);
          base_d  = wit;
          e_d     = d_q;
          state_d = S_POW;
        end
      end

      S_POW: begin
        if (e_q == '0) begin
          state_d = S_PCHK;
        end else if (e_q[0]) begin
          macc_d  = '0;
          ma_d    = acc_q;
          my_d    = base_q;
          kind_d  = K_ACC;
          state_d = S_MUL;
        end else begin
          macc_d  = '0;
          ma_d    = base_q;
          my_d    = base_q;
          kind_d  = K_BASE;
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        if (my_q != '0) begin
          if (my_q[0]) begin
            macc_d = sum_acc;
          end
          ma_d = sum_dbl;
          my_d = my_q >> 1;
        end else begin
          case (kind_q)
            K_ACC: begin
              acc_d  = macc_q;
              macc_d = '0;
              ma_d   = base_q;
              my_d   = base_q;
              kind_d = K_BASE;
            end
            K_BASE: begin
              base_d  = macc_q;
              e_d     = e_q >> 1;
              state_d = S_POW;
            end
            default: begin
              acc_d = macc_q;
              if (macc_q == n_minus_1) begin
                widx_d  = widx_q + LIMIT_W'(1);
                state_d = S_WIT;
              end else begin
                j_d     = j_q + SHIFT_W'(1);
                state_d = S_SQLOOP;
              end
            end
          endcase
        end
      end

      S_PCHK: begin
        if (acc_q == word_t'(1) || acc_q == n_minus_1) begin
          widx_d  = widx_q + LIMIT_W'(1);
          state_d = S_WIT;
        end else begin
          j_d     = SHIFT_W'(1);
          state_d = S_SQLOOP;
        end
      end

      S_SQLOOP: begin
        if (j_q >= r_q) begin
          flag_d  = 1'b0;
          state_d = S_DONE;
        end else begin
          macc_d  = '0;
          ma_d    = acc_q;
          my_d    = acc_q;
          kind_d  = K_SQR;
          state_d = S_MUL;
        end
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_ACC;
      flag_q  <= 1'b0;
      limit_q <= LIMIT_RESET;
      count_q <= '0;
      widx_q  <= '0;
      r_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      flag_q  <= flag_d;
      count_q <= count_d;
      widx_q  <= widx_d;
      r_q     <= r_d;
      j_q     <= j_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_witness_limit_i;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    d_q    <= d_d;
    e_q    <= e_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    macc_q <= macc_d;
    ma_q   <= ma_d;
    my_q   <= my_d;
  end

endmodule

>>> src/mrpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin core port checker
// Checks the core's request and result sequencing and small-value verdicts.
// ----------------------------------------------------------------------------
module mrpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [mrpt_pkg::WORD_W-1:0] candidate_i,
  input logic                        done_o,
  input logic                        prime_flag_o
);
  import mrpt_pkg::*;

  // A result is only shown while a request is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while not busy");

  // After a result the core is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("core still busy after result");

  // An accepted request makes the core busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but core not busy");

  // Values below two are answered at once as not prime.
  a_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && candidate_i < WORD_W'(2) |=> done_o && !prime_flag_o)
    else $error("small candidate answered wrongly");

endmodule

bind miller_rabin_primality_test_64_core mrpt_checker u_mrpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .candidate_i  (candidate_i),
  .done_o       (done_o),
  .prime_flag_o (prime_flag_o)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Miller-Rabin 64-bit primality test core
// Sends candidates through the start/busy request port and changes the witness
// limit between phases. Each prime_flag_o value shown with a done_o pulse is
// checked against a local model of the deterministic Miller-Rabin test at the
// limit in force when the candidate was accepted.
// ----------------------------------------------------------------------------
module tb;
  import mrpt_pkg::*;

  localparam int CLK_PERIOD   = 10;
  // The watchdog limit covers about 100 candidates, each at the slowest odd
  // case, plus idle gaps, with a margin of eight times.
  localparam int CYCLE_LIMIT  = 80_000_000;
  // This drain margin lets the core settle back to idle and shows any extra
  // done_o pulse before the next phase starts.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  word_t              candidate_i;
  logic               done_o;
  logic               prime_flag_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_witness_limit_i;

  miller_rabin_primality_test_64_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .candidate_i         (candidate_i),
    .done_o              (done_o),
    .prime_flag_o        (prime_flag_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_witness_limit_i (cfg_witness_limit_i)
  );

  // This copy of the witness limit tracks the value the core should hold. It
  // changes only at a configuration handshake, and those happen only while the
  // core is idle.
  logic [LIMIT_W-1:0] model_limit;

  // Verdicts still owed by the core, oldest first. The candidate is kept with
  // each one so that a mismatch message can name it.
  word_t pending_candidates[$];
  bit    pending_verdicts[$];

  int    mismatch_count;
  int    cycle_count;
  bit    gaps_enabled;
  word_t checked_candidate;
  bit    checked_verdict;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Verdict model
  // --------------------------------------------------------------------------

  function automatic word_t witness_prime(input int idx);
    word_t p;
    case (idx)
      0:       p = 64'd2;
      1:       p = 64'd3;
      2:       p = 64'd5;
      3:       p = 64'd7;
      4:       p = 64'd11;
      5:       p = 64'd13;
      6:       p = 64'd17;
      7:       p = 64'd19;
      8:       p = 64'd23;
      9:       p = 64'd29;
      10:      p = 64'd31;
      default: p = 64'd37;
    endcase
    return p;
  endfunction

  // The modular sum keeps the carry out of bit 63. Without it, moduli above
  // 2^63 would wrap.
  function automatic word_t sum_mod(input word_t x, input word_t y, input word_t m);
    word_t sum;
    bit    carry;
    {carry, sum} = x + y;
    if (carry || sum >= m) begin
      sum = sum - m;
    end
    return sum;
  endfunction

  function automatic word_t product_mod(input word_t x, input word_t y, input word_t m);
    word_t acc;
    word_t addend;
    word_t bits;
    acc    = '0;
    addend = x % m;
    bits   = y;
    while (bits != 0) begin
      if (bits[0]) begin
        acc = sum_mod(acc, addend, m);
      end
      addend = sum_mod(addend, addend, m);
      bits   = bits >> 1;
    end
    return acc;
  endfunction

  function automatic word_t power_mod(input word_t base, input word_t e, input word_t m);
    word_t acc;
    word_t sq;
    word_t bits;
    acc  = word_t'(1) % m;
    sq   = base % m;
    bits = e;
    while (bits != 0) begin
      if (bits[0]) begin
        acc = product_mod(acc, sq, m);
      end
      sq   = product_mod(sq, sq, m);
      bits = bits >> 1;
    end
    return acc;
  endfunction

  function automatic bit predict_prime(input word_t n, input logic [LIMIT_W-1:0] limit);
    word_t d;
    word_t x;
    word_t a;
    int    r;
    int    count;
    int    i;
    int    j;
    bit    passed;
    if (n < 2) begin
      return 1'b0;
    end
    if (n == 2 || n == 3) begin
      return 1'b1;
    end
    if (!n[0]) begin
      return 1'b0;
    end
    d = n - 1;
    r = 0;
    while (!d[0]) begin
      d = d >> 1;
      r++;
    end
    // Limits above the table size are treated as the full table.
    count = (int'(limit) > MAX_WITNESSES) ? MAX_WITNESSES : int'(limit);
    for (i = 0; i < count; i++) begin
      a = witness_prime(i);
      // A witness that is not below n tells nothing and is skipped.
      if (a >= n) begin
        continue;
      end
      x = power_mod(a, d, n);
      if (x == 1 || x == n - 1) begin
        continue;
      end
      passed = 1'b0;
      for (j = 1; j < r; j++) begin
        x = product_mod(x, x, n);
        if (x == n - 1) begin
          passed = 1'b1;
          break;
        end
      end
      if (!passed) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // done_o is sampled at the edge that ends its one-cycle pulse. The core
  // cannot hold a result back, so every pulse is taken as a result.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no request waiting, prime_flag_o=%0b",
                                  prime_flag_o));
      end else begin
        checked_candidate = pending_candidates.pop_front();
        checked_verdict   = pending_verdicts.pop_front();
        if (prime_flag_o !== checked_verdict) begin
          report_mismatch($sformatf("candidate %0d: prime_flag_o=%b, predicted %0b",
                                    checked_candidate, prime_flag_o, checked_verdict));
        end
      end
    end
  end

  // The watchdog ends a run that hangs, such as a request that is never taken
  // or a verdict that never comes.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Every driver task returns right after a rising edge, so the next task
  // drives its inputs in a fresh time step.

  // This sends one candidate. The request is taken at the first edge with busy
  // low. start drops in that same step, and the task waits one more edge before
  // it returns. start therefore never falls and rises in one step. busy is high
  // after a request is taken, so the low cycle costs no throughput.
  task automatic send_candidate(input word_t n);
    if (gaps_enabled && $urandom_range(99) < 33) begin
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start       <= 1'b1;
    candidate_i <= n;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    pending_candidates = {pending_candidates, n};
    pending_verdicts   = {pending_verdicts, predict_prime(n, model_limit)};
    // After the request is taken, junk goes on the candidate bus. The verdict
    // must come from the value the core latched.
    start       <= 1'b0;
    candidate_i <= {$urandom(), $urandom()};
    @(posedge clk_i);
  endtask

  // The sender pauses here until every outstanding verdict has arrived. The
  // core is then idle, so it is safe to reconfigure it.
  task automatic wait_for_results();
    while (pending_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_for_results();
    if (gaps_enabled && $urandom_range(99) < 33) begin
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    cfg_valid_i         <= 1'b1;
    cfg_witness_limit_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    model_limit = value;
    cfg_valid_i         <= 1'b0;
    cfg_witness_limit_i <= LIMIT_W'($urandom());
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // This runs on the reset limit of twelve, with no write before it. It covers
  // the trivial values, both ends of the range, even values, and the largest
  // 64-bit prime, which needs the carry-kept adds.
  task automatic test_reset_limit();
    send_candidate(64'd0);
    send_candidate(64'd1);
    send_candidate(64'd2);
    send_candidate(64'd3);
    send_candidate(64'd4);
    send_candidate(64'hFFFF_FFFF_FFFF_FFFF);
    send_candidate(64'hFFFF_FFFF_FFFF_FFFE);
    send_candidate(64'hFFFF_FFFF_FFFF_FFC5);
    send_candidate(64'h8000_0000_0000_0000);
  endtask

  // For candidates up to 37, some of the witnesses are not below n. Those
  // witnesses are skipped.
  task automatic test_large_witness();
    send_candidate(64'd5);
    send_candidate(64'd37);
    send_candidate(64'd41);
  endtask

  // Strong pseudoprimes pass or fail depending on how many witnesses are used.
  // 2047 fools base 2 alone, 1373653 fools bases 2 and 3, and 3215031751 fools
  // bases 2 through 7.
  task automatic test_pseudoprimes();
    write_limit(LIMIT_W'(1));
    send_candidate(64'd2047);
    write_limit(LIMIT_W'(2));
    send_candidate(64'd2047);
    send_candidate(64'd1373653);
    write_limit(LIMIT_W'(4));
    send_candidate(64'd3215031751);
  endtask

  // With no witnesses, every odd candidate of 5 or more is called prime. The
  // special small and even values still behave as usual.
  task automatic test_zero_limit();
    write_limit(LIMIT_W'(0));
    send_candidate(64'd9);
    send_candidate(64'd2047);
    send_candidate(64'd5);
    send_candidate(64'd4);
  endtask

  // Limits of 13 to 15 saturate to the full table. The first number is a
  // strong pseudoprime to every base up to 23, so only the last witnesses
  // catch it.
  task automatic test_limit_saturation();
    write_limit(LIMIT_W'(15));
    send_candidate(64'd3825123056546413051);
    send_candidate(64'd561);
    write_limit(LIMIT_W'(13));
    send_candidate(64'hFFFF_FFFF_FFFF_FFC5);
  endtask

  // The random test runs in phases of twenty candidates, with a random limit
  // per phase. Before each write the sender drains all outstanding verdicts.
  // Most odd candidates are kept small, because run time grows with the
  // exponent width. A quarter are real primes, so every witness within the
  // limit is tried and passes. Candidates in the middle of the run go out
  // with no idle gaps.
  task automatic test_random_candidates();
    int    k;
    int    kind;
    int    width;
    word_t n;
    word_t mask;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      gaps_enabled = !(k >= 40 && k < 70);
      if (k % 20 == 0) begin
        write_limit(LIMIT_W'($urandom_range(0, 15)));
      end
      kind = $urandom_range(99);
      n    = {$urandom(), $urandom()};
      if (kind < 15) begin
        n[0] = 1'b0;
        if ($urandom_range(1)) begin
          n = n >> $urandom_range(0, 63);
        end
      end else if (kind < 20) begin
        n = word_t'($urandom_range(0, 3));
      end else if (kind < 45) begin
        width = $urandom_range(3, 24);
        mask  = (word_t'(1) << width) - 1;
        n     = (n & mask) | word_t'(1);
      end else if (kind < 70) begin
        width = $urandom_range(8, 32);
        mask  = (word_t'(1) << width) - 1;
        n     = (n & mask) | (word_t'(1) << (width - 1)) | word_t'(1);
        // The limit of twelve makes the model exact for 64 bits, so it can
        // find the next prime.
        while (!predict_prime(n, LIMIT_RESET)) begin
          n = n + 2;
        end
      end
      send_candidate(n);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    start               = 1'b0;
    candidate_i         = '0;
    cfg_valid_i         = 1'b0;
    cfg_witness_limit_i = '0;
    rst_ni              = 1'b0;
    mismatch_count      = 0;
    gaps_enabled        = 1'b1;
    model_limit         = LIMIT_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_limit();
    test_large_witness();
    test_pseudoprimes();
    test_zero_limit();
    test_limit_saturation();
    test_random_candidates();

    // All stimulus has been accepted. The checker pops each verdict as it
    // arrives, so an empty store here means nothing is still owed.
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mrpt_pkg.sv
src/miller_rabin_primality_test_64_core.sv
src/mrpt_checker.sv
test/tb.sv
